// ----- hw/rtl/tsrsc_pkg.sv -----
// Shared types, codes and constants for the train speed ramp station controller.
package tsrsc_pkg;

   localparam int unsigned NOW_WIDTH   = 32;
   localparam int unsigned MS_WIDTH    = 16;
   localparam int unsigned SPEED_WIDTH = 8;
   localparam int unsigned STEP_WIDTH  = 7;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   typedef enum logic [2:0] {
      MODE_STOPPED   = 3'd0,
      MODE_RAMP_UP   = 3'd1,
      MODE_RUNNING   = 3'd2,
      MODE_RAMP_DOWN = 3'd3,
      MODE_STATION   = 3'd4,
      MODE_EMERGENCY = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      REQ_TICK      = 3'd0,
      REQ_START     = 3'd1,
      REQ_STOP      = 3'd2,
      REQ_ESTOP     = 3'd3,
      REQ_RELEASE   = 3'd4,
      REQ_DIRECTION = 3'd5
   } req_code_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SENSOR_COOLDOWN = 3'd0,
      CSR_FWD_BRAKE_DELAY = 3'd1,
      CSR_REV_BRAKE_DELAY = 3'd2,
      CSR_STATION_WAIT    = 3'd3,
      CSR_CRUISE_SPEED    = 3'd4,
      CSR_RAMP_INTERVAL   = 3'd5,
      CSR_MIN_SPEED       = 3'd6,
      CSR_ACCEL_STEP      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [NOW_WIDTH-1:0] now_ms;
      logic                 sensor_hit;
      logic                 wanted_forward;
   } tsrsc_req_type;

   typedef struct packed {
      logic [SPEED_WIDTH-1:0] speed;
      logic                   forward;
      logic [2:0]             mode;
      logic                   power_update;
   } tsrsc_rsp_type;

   typedef struct packed {
      logic [MS_WIDTH-1:0]    sensor_cooldown_ms;
      logic [MS_WIDTH-1:0]    forward_brake_delay_ms;
      logic [MS_WIDTH-1:0]    reverse_brake_delay_ms;
      logic [MS_WIDTH-1:0]    station_wait_ms;
      logic [SPEED_WIDTH-1:0] cruise_speed;
      logic [MS_WIDTH-1:0]    ramp_interval_ms;
      logic [SPEED_WIDTH-1:0] min_speed;
      logic [STEP_WIDTH-1:0]  accel_step;
   } tsrsc_cfg_type;

   typedef struct packed {
      mode_type               mode;
      logic [SPEED_WIDTH-1:0] speed;
      logic [SPEED_WIDTH-1:0] target;
      logic                   forward;
      logic                   sensor_stop;
      logic                   brake_armed;
      logic [NOW_WIDTH-1:0]   brake_mark_ms;
      logic [MS_WIDTH-1:0]    brake_window_ms;
      logic [NOW_WIDTH-1:0]   last_sensor_ms;
      logic [NOW_WIDTH-1:0]   station_start_ms;
      logic [NOW_WIDTH-1:0]   last_ramp_ms;
      logic                   flip_pending;
      logic                   flip_forward;
   } tsrsc_state_type;

   localparam logic [STEP_WIDTH-1:0] ACCEL_STEP_RESET = 7'd1;

endpackage

// ----- hw/rtl/train_speed_ramp_station_controller_core.sv -----
// Top level of the train speed ramp station controller.
// This block sequences the motor speed of a model train. Each request word is a tick
// (carrying the millisecond time and the trackside sensor level) or an operator command
// (start, stop, emergency stop, release, direction request), and each one yields exactly
// one result word with the speed, direction, mode and a flag that says the bridge was
// written. A request word is captured in an input register, the whole sequencer step
// (sensor debounce, brake delay, station wait, ramp update, direction flip) is evaluated
// combinationally against the state registers, and the result lands in an output register.
// The block therefore takes one word per cycle while the output is not stalled. A word
// passes the input register and then the output register before its result word is shown.
// The input register keeps taking a word while a finished result waits on a
// stalled output, and back pressure reaches req_stall only when both registers are full
// and the output is stalled. The configuration registers are written through the csr_
// port, which is always ready; they must be written only while no request word is in
// flight.
module train_speed_ramp_station_controller_core
   import tsrsc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tsrsc_req_type             req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tsrsc_rsp_type             rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   // Configuration registers.
   tsrsc_cfg_type   cfg_ff;
   tsrsc_cfg_type   cfg_in;
   tsrsc_cfg_type   cfg_reset;

   // Sequencer state carried from one request word to the next.
   tsrsc_state_type state_ff;
   tsrsc_state_type state_in;
   tsrsc_state_type state_nxt;
   tsrsc_state_type state_reset;

   // Input register and output register.
   logic            in_valid_ff;
   logic            in_valid_in;
   tsrsc_req_type   in_data_ff;
   tsrsc_req_type   in_data_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   tsrsc_rsp_type   rsp_data_ff;
   tsrsc_rsp_type   rsp_data_in;
   tsrsc_rsp_type   step_rsp;

   logic            advance;
   logic            req_take;

   assign csr_ready = 1'b1;

   // The word in the input register moves on when the output register is empty or
   // is being emptied in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tsrsc_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .req       (in_data_ff),
      .state_nxt (state_nxt),
      .rsp       (step_rsp)
   );

   // Values loaded at reset: everything zero except the step and the direction; the mode is MODE_STOPPED.
   always_comb begin
      cfg_reset              = '0;
      cfg_reset.accel_step   = ACCEL_STEP_RESET;
      state_reset            = '0;
      state_reset.mode       = MODE_STOPPED;
      state_reset.forward    = 1'b1;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SENSOR_COOLDOWN: cfg_in.sensor_cooldown_ms     = csr_data;
            CSR_FWD_BRAKE_DELAY: cfg_in.forward_brake_delay_ms = csr_data;
            CSR_REV_BRAKE_DELAY: cfg_in.reverse_brake_delay_ms = csr_data;
            CSR_STATION_WAIT:    cfg_in.station_wait_ms        = csr_data;
            CSR_CRUISE_SPEED:    cfg_in.cruise_speed           = csr_data[SPEED_WIDTH-1:0];
            CSR_RAMP_INTERVAL:   cfg_in.ramp_interval_ms       = csr_data;
            CSR_MIN_SPEED:       cfg_in.min_speed              = csr_data[SPEED_WIDTH-1:0];
            CSR_ACCEL_STEP:      cfg_in.accel_step             = csr_data[STEP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = advance ? state_nxt : state_ff;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_data_in   = req_take ? req_data : in_data_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_data_in  = advance ? step_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                      <= cfg_reset;
         state_ff                    <= state_reset;
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff                      <= cfg_in;
         state_ff                    <= state_in;
         in_valid_ff                 <= in_valid_in;
         rsp_valid_ff                <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The train never moves while stopped or in emergency.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == MODE_STOPPED || state_ff.mode == MODE_EMERGENCY)
         |-> (state_ff.speed == '0))
      else $error("nonzero speed while stopped or in emergency");

   // A pending direction flip is always dropped on an emergency stop.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.flip_pending |-> (state_ff.mode != MODE_EMERGENCY))
      else $error("direction flip pending during emergency");

   // Every word that leaves the input register shows up as a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed word produced no result");

   // Back pressure only when both the input and output registers are occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

endmodule

// ----- hw/rtl/tsrsc_step.sv -----
// Next-state and result logic for one request word of the speed sequencer.
module tsrsc_step
   import tsrsc_pkg::*;
(
   input  tsrsc_state_type state_cur,
   input  tsrsc_cfg_type   cfg,
   input  tsrsc_req_type   req,
   output tsrsc_state_type state_nxt,
   output tsrsc_rsp_type   rsp
);

   always_comb begin
      tsrsc_state_type       s;
      logic                  pu;
      logic                  emerg;
      logic [NOW_WIDTH-1:0]  now;
      logic [8:0]            up_sum;
      logic [SPEED_WIDTH-1:0] up_speed;
      logic signed [9:0]     down_next;

      s         = state_cur;
      pu        = 1'b0;
      emerg     = (state_cur.mode == MODE_EMERGENCY);
      now       = req.now_ms;
      up_sum    = '0;
      up_speed  = '0;
      down_next = '0;

      case (req.req_type)
         REQ_TICK: begin
            if (!emerg) begin
               // Debounced sensor trigger arms the direction-dependent brake delay.
               if (req.sensor_hit &&
                   ((now - s.last_sensor_ms) >= {16'b0, cfg.sensor_cooldown_ms})) begin
                  s.last_sensor_ms = now;
                  if (s.mode == MODE_RUNNING && s.speed != '0 && !s.brake_armed) begin
                     s.brake_armed     = 1'b1;
                     s.brake_mark_ms   = now;
                     s.brake_window_ms = s.forward ? cfg.forward_brake_delay_ms
                                                   : cfg.reverse_brake_delay_ms;
                  end
               end
               if (s.brake_armed &&
                   ((now - s.brake_mark_ms) >= {16'b0, s.brake_window_ms})) begin
                  s.brake_armed = 1'b0;
                  if (s.mode == MODE_RUNNING && s.speed != '0) begin
                     s.mode        = MODE_RAMP_DOWN;
                     s.target      = '0;
                     s.sensor_stop = 1'b1;
                  end
               end
               if (s.mode == MODE_STATION &&
                   ((now - s.station_start_ms) >= {16'b0, cfg.station_wait_ms})) begin
                  s.target = cfg.cruise_speed;
                  s.mode   = MODE_RAMP_UP;
               end

               // Momentum: one ramp update per interval.
               if ((now - s.last_ramp_ms) >= {16'b0, cfg.ramp_interval_ms}) begin
                  s.last_ramp_ms = now;
                  if (s.speed != s.target) begin
                     pu = 1'b1;
                     if (s.speed < s.target) begin
                        if (s.speed == '0) begin
                           up_speed = (cfg.min_speed > s.target) ? s.target : cfg.min_speed;
                        end else begin
                           up_sum   = {1'b0, s.speed} + {2'b0, cfg.accel_step};
                           up_speed = (up_sum > {1'b0, s.target}) ? s.target
                                                                  : up_sum[SPEED_WIDTH-1:0];
                        end
                        s.speed = up_speed;
                     end else begin
                        down_next = $signed({2'b0, s.speed})
                                    - $signed({2'b0, cfg.accel_step, 1'b0});
                        if (s.target == '0 && down_next <= $signed({2'b0, cfg.min_speed})) begin
                           down_next = '0;
                        end
                        if (down_next < $signed({2'b0, s.target})) begin
                           down_next = $signed({2'b0, s.target});
                        end
                        s.speed = down_next[SPEED_WIDTH-1:0];
                     end

                     if (s.speed == '0) begin
                        if (s.flip_pending) begin
                           s.flip_pending = 1'b0;
                           s.forward      = s.flip_forward;
                           s.target       = cfg.cruise_speed;
                           s.mode         = MODE_RAMP_UP;
                        end else if (s.target == '0) begin
                           if (s.sensor_stop) begin
                              s.mode             = MODE_STATION;
                              s.station_start_ms = now;
                           end else begin
                              s.mode = MODE_STOPPED;
                           end
                           s.sensor_stop = 1'b0;
                        end
                     end else if (s.speed == s.target) begin
                        s.mode = MODE_RUNNING;
                     end
                  end
               end
            end
         end
         REQ_START: begin
            if (!emerg) begin
               s.target      = cfg.cruise_speed;
               s.mode        = MODE_RAMP_UP;
               s.sensor_stop = 1'b0;
               s.brake_armed = 1'b0;
            end
         end
         REQ_STOP: begin
            if (!emerg) begin
               s.target       = '0;
               s.mode         = MODE_RAMP_DOWN;
               s.sensor_stop  = 1'b0;
               s.brake_armed  = 1'b0;
               s.flip_pending = 1'b0;
            end
         end
         REQ_ESTOP: begin
            s.speed        = '0;
            s.target       = '0;
            s.mode         = MODE_EMERGENCY;
            s.sensor_stop  = 1'b0;
            s.brake_armed  = 1'b0;
            s.flip_pending = 1'b0;
            pu             = 1'b1;
         end
         REQ_RELEASE: begin
            if (emerg) begin
               s.mode = MODE_STOPPED;
            end
         end
         REQ_DIRECTION: begin
            if (!emerg && req.wanted_forward != s.forward) begin
               if (s.speed == '0 && s.target == '0) begin
                  s.forward = req.wanted_forward;
               end else begin
                  s.flip_pending = 1'b1;
                  s.flip_forward = req.wanted_forward;
                  s.target       = '0;
                  s.mode         = MODE_RAMP_DOWN;
                  s.sensor_stop  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      state_nxt        = s;
      rsp.speed        = s.speed;
      rsp.forward      = s.forward;
      rsp.mode         = s.mode;
      rsp.power_update = pu;
   end

endmodule
